// ===== rtl/hsjc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsjc_pkg
// Types and constants shared by the stepper homing and jog controller.
// ----------------------------------------------------------------------------
package hsjc_pkg;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 20;
	localparam int PULSE_BITS     = 16;
	localparam int SETTLE_BITS    = 20;
	localparam int STEPS_BITS     = 16;

	localparam logic [PULSE_BITS-1:0]  EXTEND_PULSE_RESET = 16'd60;
	localparam logic [PULSE_BITS-1:0]  SHRINK_PULSE_RESET = 16'd90;
	localparam logic [PULSE_BITS-1:0]  HOMING_PULSE_RESET = 16'd30;
	localparam logic [PULSE_BITS-1:0]  STEP_GAP_RESET     = 16'd1;
	localparam logic [SETTLE_BITS-1:0] SETTLE_RESET       = 20'd100000;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_EXTEND_PULSE = 3'd0,
		CFG_SHRINK_PULSE = 3'd1,
		CFG_HOMING_PULSE = 3'd2,
		CFG_STEP_GAP     = 3'd3,
		CFG_SETTLE       = 3'd4
	} cfg_index_t;

	typedef enum logic [3:0] {
		PH_SEEK_LEFT   = 4'd0,
		PH_MEASURE     = 4'd1,
		PH_CENTER      = 4'd2,
		PH_EXTEND      = 4'd3,
		PH_SETTLE_EXT  = 4'd4,
		PH_SHRINK      = 4'd5,
		PH_SETTLE_SHR  = 4'd6,
		PH_HOME_CHECK  = 4'd7,
		PH_SETTLE_HOME = 4'd8
	} phase_t;

	typedef struct packed {
		logic [PULSE_BITS-1:0]  extend_pulse_ticks;
		logic [PULSE_BITS-1:0]  shrink_pulse_ticks;
		logic [PULSE_BITS-1:0]  homing_pulse_ticks;
		logic [PULSE_BITS-1:0]  step_gap_ticks;
		logic [SETTLE_BITS-1:0] settle_ticks;
	} cfg_t;

	typedef struct packed {
		logic limit_left;
		logic limit_right;
		logic extend_req;
		logic shrink_req;
	} in_item_t;

	typedef struct packed {
		logic                  step_out;
		logic                  dir_out;
		logic [3:0]            phase;
		logic [STEPS_BITS-1:0] travel_steps;
	} out_item_t;

endpackage

// ===== rtl/hsjc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsjc_cfg_regs
// Configuration register bank: pulse widths, step gap and settle length.
// ----------------------------------------------------------------------------
module hsjc_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [hsjc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [hsjc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output hsjc_pkg::cfg_t                      cfg
);
	import hsjc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.extend_pulse_ticks <= EXTEND_PULSE_RESET;
			cfg_q.shrink_pulse_ticks <= SHRINK_PULSE_RESET;
			cfg_q.homing_pulse_ticks <= HOMING_PULSE_RESET;
			cfg_q.step_gap_ticks     <= STEP_GAP_RESET;
			cfg_q.settle_ticks       <= SETTLE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_EXTEND_PULSE: cfg_q.extend_pulse_ticks <= cfg_data[PULSE_BITS-1:0];
				CFG_SHRINK_PULSE: cfg_q.shrink_pulse_ticks <= cfg_data[PULSE_BITS-1:0];
				CFG_HOMING_PULSE: cfg_q.homing_pulse_ticks <= cfg_data[PULSE_BITS-1:0];
				CFG_STEP_GAP:     cfg_q.step_gap_ticks     <= cfg_data[PULSE_BITS-1:0];
				CFG_SETTLE:       cfg_q.settle_ticks       <= cfg_data[SETTLE_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/hsjc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsjc_core
// Per-tick phase sequencer, pulse timer, settle timer and step counters.
// ----------------------------------------------------------------------------
module hsjc_core #(
	parameter int COUNT_BITS = 16,
	parameter int WAIT_BITS  = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  hsjc_pkg::cfg_t      cfg,
	input  hsjc_pkg::in_item_t  item,
	output hsjc_pkg::out_item_t result
);
	import hsjc_pkg::*;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [WAIT_BITS-1:0]  WAIT_MAX  = '1;

	phase_t                 phase_q, phase_d;
	logic [PULSE_BITS-1:0]  pulse_timer_q, pulse_timer_d;
	logic                   pulse_active_q, pulse_active_d;
	logic [WAIT_BITS-1:0]   wait_timer_q, wait_timer_d;
	logic [COUNT_BITS-1:0]  travel_q, travel_d;
	logic [COUNT_BITS-1:0]  center_q, center_d;
	logic                   dir_q, dir_d;
	logic                   recheck_q, recheck_d;
	logic                   step_d;

	logic                   start_pulse;
	logic [PULSE_BITS-1:0]  pulse_width;
	logic [WAIT_BITS-1:0]   settle_load;
	logic [31:0]            settle_ext;
	logic [31:0]            travel_ext;

	assign settle_ext  = 32'(cfg.settle_ticks);
	assign settle_load = (settle_ext > 32'(WAIT_MAX)) ? WAIT_MAX : WAIT_BITS'(settle_ext);

	always_comb begin
		phase_d        = phase_q;
		pulse_timer_d  = pulse_timer_q;
		pulse_active_d = pulse_active_q;
		wait_timer_d   = wait_timer_q;
		travel_d       = travel_q;
		center_d       = center_q;
		dir_d          = dir_q;
		recheck_d      = recheck_q;
		step_d         = 1'b0;
		start_pulse    = 1'b0;
		pulse_width    = cfg.homing_pulse_ticks;

		if (pulse_active_q) begin
			step_d        = 1'b1;
			pulse_timer_d = pulse_timer_q - 1'b1;
			if (pulse_timer_q == PULSE_BITS'(1)) begin
				pulse_active_d = 1'b0;
				pulse_timer_d  = cfg.step_gap_ticks;
			end
		end else if (pulse_timer_q != '0) begin
			pulse_timer_d = pulse_timer_q - 1'b1;
		end else begin
			unique case (phase_q) inside
				PH_SEEK_LEFT: begin
					if (!item.limit_left) begin
						start_pulse = 1'b1;
						dir_d       = 1'b1;
					end else begin
						travel_d = '0;
						phase_d  = PH_MEASURE;
					end
				end
				PH_MEASURE: begin
					if (!item.limit_right) begin
						start_pulse = 1'b1;
						dir_d       = 1'b0;
						if (travel_q != COUNT_MAX)
							travel_d = travel_q + 1'b1;
					end else begin
						center_d = '0;
						phase_d  = PH_CENTER;
					end
				end
				PH_CENTER: begin
					if (center_q < (travel_q >> 1)) begin
						start_pulse = 1'b1;
						dir_d       = 1'b1;
						center_d    = center_q + 1'b1;
					end else begin
						phase_d   = recheck_q ? PH_HOME_CHECK : PH_EXTEND;
						recheck_d = 1'b0;
					end
				end
				PH_EXTEND: begin
					if (item.extend_req && !item.shrink_req && !item.limit_right) begin
						start_pulse = 1'b1;
						pulse_width = cfg.extend_pulse_ticks;
						dir_d       = 1'b0;
					end else begin
						phase_d      = PH_SETTLE_EXT;
						wait_timer_d = settle_load;
					end
				end
				PH_SHRINK: begin
					if (item.shrink_req && !item.extend_req && !item.limit_left) begin
						start_pulse = 1'b1;
						pulse_width = cfg.shrink_pulse_ticks;
						dir_d       = 1'b1;
					end else begin
						phase_d      = PH_SETTLE_SHR;
						wait_timer_d = settle_load;
					end
				end
				PH_HOME_CHECK: begin
					if (item.shrink_req && item.extend_req) begin
						recheck_d = 1'b1;
						phase_d   = PH_SEEK_LEFT;
					end else begin
						phase_d      = PH_SETTLE_HOME;
						wait_timer_d = settle_load;
					end
				end
				PH_SETTLE_EXT, PH_SETTLE_SHR, PH_SETTLE_HOME: begin
					if (wait_timer_q != '0) begin
						wait_timer_d = wait_timer_q - 1'b1;
					end else if (phase_q == PH_SETTLE_EXT) begin
						phase_d = PH_SHRINK;
					end else if (phase_q == PH_SETTLE_SHR) begin
						phase_d = PH_HOME_CHECK;
					end else begin
						phase_d = PH_EXTEND;
					end
				end
				default: begin
					recheck_d = 1'b0;
					phase_d   = PH_SEEK_LEFT;
				end
			endcase

			if (start_pulse) begin
				step_d = 1'b1;
				if (pulse_width > PULSE_BITS'(1)) begin
					pulse_active_d = 1'b1;
					pulse_timer_d  = pulse_width - 1'b1;
				end else begin
					pulse_active_d = 1'b0;
					pulse_timer_d  = cfg.step_gap_ticks;
				end
			end
		end
	end

	assign travel_ext = 32'(travel_d);

	always_comb begin
		result.step_out     = step_d;
		result.dir_out      = dir_d;
		result.phase        = phase_q;
		result.travel_steps = travel_ext[STEPS_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_SEEK_LEFT;
			pulse_timer_q  <= '0;
			pulse_active_q <= 1'b0;
			wait_timer_q   <= '0;
			travel_q       <= '0;
			center_q       <= '0;
			dir_q          <= 1'b0;
			recheck_q      <= 1'b0;
		end else if (en) begin
			phase_q        <= phase_d;
			pulse_timer_q  <= pulse_timer_d;
			pulse_active_q <= pulse_active_d;
			wait_timer_q   <= wait_timer_d;
			travel_q       <= travel_d;
			center_q       <= center_d;
			dir_q          <= dir_d;
			recheck_q      <= recheck_d;
		end
	end

endmodule

// ===== rtl/stepper_homing_jog_controller_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_homing_jog_controller_top
// Stepper homing and jog controller: one tick transaction in, one result out.
//
//   Channel  Handshake                    Payload
//   config   cfg_we                       cfg_index, cfg_data
//   item     item_valid / item_ready      item (limit switches, buttons)
//   result   result_valid / result_ready  result (step, dir, phase, steps)
//
// A tick transaction is registered, evaluated against the controller state
// and written to the result register: one transaction per cycle sustained
// while result_ready does not hold a result back. With a result waiting, a
// new tick is still taken if the input register is empty. Reset puts the
// controller at the start of homing with the register defaults loaded.
// ----------------------------------------------------------------------------
module stepper_homing_jog_controller_top #(
	parameter int COUNT_BITS = 16,
	parameter int WAIT_BITS  = 20
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [hsjc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [hsjc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  hsjc_pkg::in_item_t                  item,
	output logic                                result_valid,
	input  logic                                result_ready,
	output hsjc_pkg::out_item_t                 result
);
	import hsjc_pkg::*;

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result_d;
	out_item_t result_q;
	logic      result_valid_q;
	logic      advance;

	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	hsjc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hsjc_core #(
		.COUNT_BITS (COUNT_BITS),
		.WAIT_BITS  (WAIT_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.cfg    (cfg),
		.item   (item_s1),
		.result (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (item_ready)
				valid_s1 <= item_valid;
			if (advance)
				result_valid_q <= 1'b1;
			else if (result_ready)
				result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid)
			item_s1 <= item;
		if (advance)
			result_q <= result_d;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
